>>> sv/jse_pkg.sv
// Shared types, character codes and helper functions for the JSON string escaper.
// Used by jse_front, jse_queue, jse_back and the top level; depends on nothing.
package jse_pkg;

   // Request kinds carried on the input tuser
   localparam logic [1:0] REQ_BEGIN = 2'd0;
   localparam logic [1:0] REQ_BYTE  = 2'd1;
   localparam logic [1:0] REQ_END   = 2'd2;

   // Configuration register indexes
   localparam logic CSR_CAPACITY   = 1'b0;
   localparam logic CSR_ESC_SLASH  = 1'b1;

   localparam logic [15:0] CAPACITY_RESET = 16'd256;
   // Bytes kept free after every sequence: closing quote and terminator
   localparam logic [2:0]  RESERVE_BYTES  = 3'd2;

   // Character codes
   localparam logic [7:0] CHAR_QUOTE  = 8'h22;
   localparam logic [7:0] CHAR_BSLASH = 8'h5c;
   localparam logic [7:0] CHAR_SLASH  = 8'h2f;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_U      = 8'h75;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_LC_B   = 8'h62;
   localparam logic [7:0] CHAR_LC_F   = 8'h66;
   localparam logic [7:0] CHAR_LC_N   = 8'h6e;
   localparam logic [7:0] CHAR_LC_R   = 8'h72;
   localparam logic [7:0] CHAR_LC_T   = 8'h74;
   localparam logic [7:0] CTRL_BS     = 8'h08;
   localparam logic [7:0] CTRL_FF     = 8'h0c;
   localparam logic [7:0] CTRL_LF     = 8'h0a;
   localparam logic [7:0] CTRL_CR     = 8'h0d;
   localparam logic [7:0] CTRL_TAB    = 8'h09;

   // Kind of output sequence queued between front and back
   typedef enum logic [2:0] {
      SEQ_OPEN,
      SEQ_CLOSE,
      SEQ_BARE_END,
      SEQ_PLAIN,
      SEQ_ESC2,
      SEQ_ESC6
   } seq_kind_type;

   // One queued sequence: kind, payload byte and reported length
   typedef struct packed {
      seq_kind_type kind;
      logic [7:0]   data;
      logic [15:0]  total;
   } seq_type;

   // Number of bytes a sequence puts out
   function automatic logic [2:0] seq_len(input seq_kind_type kind);
      logic [2:0] len;
      case (kind)
         SEQ_ESC2: len = 3'd2;
         SEQ_ESC6: len = 3'd6;
         default:  len = 3'd1;
      endcase
      return len;
   endfunction

   // Lower-case hex digit
   function automatic logic [7:0] hex_digit(input logic [3:0] nib);
      logic [7:0] ch;
      if (nib < 4'd10) ch = CHAR_ZERO + {4'h0, nib};
      else             ch = 8'h57 + {4'h0, nib};
      return ch;
   endfunction

endpackage

>>> sv/jse_queue.sv
// Short register queue of output sequences between front and back.
// Depends on jse_pkg for the sequence type.
module jse_queue #(
   parameter int DEPTH = 4
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  jse_pkg::seq_type push_data,
   input  logic            pop,
   output logic            full,
   output logic            head_valid,
   output jse_pkg::seq_type head
);
   import jse_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   seq_type          entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == FULL_CNT);
   assign head_valid = (count_ff != '0);
   assign head       = entry_ff[rd_ptr_ff];

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store pushed entries
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> sv/jse_front.sv
// Front end: configuration registers, string state, request classification
// and budget check. Depends on jse_pkg; feeds jse_queue.
module jse_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [1:0]       req_kind,
   input  logic [7:0]       req_byte,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [15:0]      csr_wdata,
   input  logic             q_full,
   output logic             q_push,
   output jse_pkg::seq_type q_data
);
   import jse_pkg::*;

   logic [15:0] capacity_ff;
   logic        esc_slash_ff;
   logic        open_ff, open_in;
   logic        trunc_ff, trunc_in;
   logic [15:0] used_ff, used_in;

   seq_kind_type byte_kind;
   logic [7:0]   byte_data;
   logic [2:0]   byte_len;
   logic [16:0]  need;
   logic         fits;
   logic         accept;

   assign req_ready = !q_full;
   assign accept    = req_valid && !q_full;

   // Classify a source byte into plain, short escape or unicode escape
   always_comb begin
      byte_kind = SEQ_PLAIN;
      byte_data = req_byte;
      if (req_byte >= CHAR_SPACE) begin
         if (req_byte == CHAR_QUOTE || req_byte == CHAR_BSLASH ||
             (req_byte == CHAR_SLASH && esc_slash_ff)) begin
            byte_kind = SEQ_ESC2;
         end
      end else begin
         byte_kind = SEQ_ESC2;
         unique case (req_byte)
            CTRL_BS:  byte_data = CHAR_LC_B;
            CTRL_FF:  byte_data = CHAR_LC_F;
            CTRL_LF:  byte_data = CHAR_LC_N;
            CTRL_CR:  byte_data = CHAR_LC_R;
            CTRL_TAB: byte_data = CHAR_LC_T;
            default:  byte_kind = SEQ_ESC6;
         endcase
      end
   end

   // Sequence fits if capacity covers used bytes, sequence and reserve
   assign byte_len = seq_len(byte_kind);
   assign need     = {1'b0, used_ff} + {14'h0, byte_len} + {14'h0, RESERVE_BYTES};
   assign fits     = ({1'b0, capacity_ff} >= need);

   // Next string state and queued sequence
   always_comb begin
      open_in      = open_ff;
      trunc_in     = trunc_ff;
      used_in      = used_ff;
      q_push       = 1'b0;
      q_data.kind  = SEQ_PLAIN;
      q_data.data  = byte_data;
      q_data.total = '0;
      if (accept) begin
         unique case (req_kind)
            REQ_BEGIN: begin
               open_in  = 1'b0;
               trunc_in = 1'b0;
               used_in  = '0;
               if (capacity_ff > 16'd2) begin
                  open_in     = 1'b1;
                  used_in     = 16'd1;
                  q_push      = 1'b1;
                  q_data.kind = SEQ_OPEN;
               end
            end
            REQ_END: begin
               q_push = 1'b1;
               if (open_ff) begin
                  q_data.kind  = SEQ_CLOSE;
                  q_data.total = used_ff + 16'd1;
               end else begin
                  q_data.kind = SEQ_BARE_END;
               end
               open_in  = 1'b0;
               trunc_in = 1'b0;
               used_in  = '0;
            end
            REQ_BYTE: begin
               if (open_ff && !trunc_ff) begin
                  if (fits) begin
                     q_push      = 1'b1;
                     q_data.kind = byte_kind;
                     used_in     = used_ff + {13'h0, byte_len};
                  end else begin
                     trunc_in = 1'b1;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff  <= 1'b0;
         trunc_ff <= 1'b0;
         used_ff  <= '0;
      end else begin
         open_ff  <= open_in;
         trunc_ff <= trunc_in;
         used_ff  <= used_in;
      end
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= CAPACITY_RESET;
         esc_slash_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_CAPACITY:  capacity_ff  <= csr_wdata;
            CSR_ESC_SLASH: esc_slash_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

endmodule

>>> sv/jse_back.sv
// Back end: expands queued sequences into output bytes, one per cycle while the
// output is ready, into a registered output stage. Depends on jse_pkg; fed by jse_queue.
module jse_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   input  jse_pkg::seq_type q_head,
   output logic             q_pop,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [7:0]       out_byte,
   output logic             out_byte_valid,
   output logic             out_last,
   output logic [15:0]      out_total
);
   import jse_pkg::*;

   logic [2:0]  idx_ff, idx_in;
   logic        valid_ff, valid_in;
   logic [7:0]  byte_ff, byte_in;
   logic        bvalid_ff, bvalid_in;
   logic        last_ff, last_in;
   logic [15:0] total_ff, total_in;
   logic        advance;
   logic        seq_done;

   assign advance  = q_valid && (!valid_ff || out_ready);
   assign seq_done = (idx_ff == seq_len(q_head.kind) - 3'd1);
   assign q_pop    = advance && seq_done;

   // Select the byte at the current position of the head sequence
   always_comb begin
      byte_in   = CHAR_QUOTE;
      bvalid_in = 1'b1;
      last_in   = 1'b0;
      total_in  = '0;
      unique case (q_head.kind)
         SEQ_OPEN: byte_in = CHAR_QUOTE;
         SEQ_CLOSE: begin
            byte_in  = CHAR_QUOTE;
            last_in  = 1'b1;
            total_in = q_head.total;
         end
         SEQ_BARE_END: begin
            byte_in   = '0;
            bvalid_in = 1'b0;
            last_in   = 1'b1;
         end
         SEQ_PLAIN: byte_in = q_head.data;
         SEQ_ESC2:  byte_in = (idx_ff == 3'd0) ? CHAR_BSLASH : q_head.data;
         SEQ_ESC6: begin
            case (idx_ff)
               3'd0:    byte_in = CHAR_BSLASH;
               3'd1:    byte_in = CHAR_U;
               3'd4:    byte_in = hex_digit(q_head.data[7:4]);
               3'd5:    byte_in = hex_digit(q_head.data[3:0]);
               default: byte_in = CHAR_ZERO;
            endcase
         end
         default: ;
      endcase
   end

   // Step position and output valid
   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (advance) begin
         idx_in   = seq_done ? 3'd0 : idx_ff + 3'd1;
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   // Load output payload
   always_ff @(posedge clock) begin
      if (advance) begin
         byte_ff   <= byte_in;
         bvalid_ff <= bvalid_in;
         last_ff   <= last_in;
         total_ff  <= total_in;
      end
   end

   assign out_valid      = valid_ff;
   assign out_byte       = byte_ff;
   assign out_byte_valid = bvalid_ff;
   assign out_last       = last_ff;
   assign out_total      = total_ff;

endmodule

>>> sv/json_string_escaper.sv
// JSON string escaper: begin, byte and end requests become a quoted, escaped
// JSON string within a byte budget set by the capacity register; each end
// request yields one result with tlast and, for an open string, the total length.
// The front end takes one request per cycle while its QUEUE_DEPTH-entry
// sequence queue has room; the back end puts out one byte per cycle while the
// result side is ready, a short escape as two bytes and a unicode escape as six,
// and the input stalls only once the queue has filled behind a run of escapes
// or a stalled output. Requests pass the queue and the output register. Top
// level; depends on jse_pkg, jse_front, jse_queue and jse_back.
module json_string_escaper #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic [1:0]  req_tuser,   // [1:0] req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] out_byte, [23:8] total_length
   output logic [0:0]  rsp_tuser,   // [0] byte_valid
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);
   import jse_pkg::*;

   seq_type     q_data;
   seq_type     q_head;
   logic        q_push;
   logic        q_pop;
   logic        q_full;
   logic        q_valid;
   logic [7:0]  out_byte;
   logic [15:0] out_total;

   jse_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_kind  (req_tuser),
      .req_byte  (req_tdata),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_data    (q_data)
   );

   jse_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (q_data),
      .pop        (q_pop),
      .full       (q_full),
      .head_valid (q_valid),
      .head       (q_head)
   );

   jse_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_head         (q_head),
      .q_pop          (q_pop),
      .out_valid      (rsp_tvalid),
      .out_ready      (rsp_tready),
      .out_byte       (out_byte),
      .out_byte_valid (rsp_tuser[0]),
      .out_last       (rsp_tlast),
      .out_total      (out_total)
   );

   assign rsp_tdata = {out_total, out_byte};

endmodule

>>> sv/jse_checker.sv
// Port-level checks on the JSON string escaper result stream, with the bind
// that attaches them to json_string_escaper. Depends on the top level only.
module jse_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic [0:0]  rsp_tuser,
   input logic        rsp_tlast
);

   // Hold a stalled result transaction
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
      $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // Length is reported only on the final result of a string
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tdata[23:8] == 16'd0)
      else $error("length on a non-final result");

   // A result without a byte is a bare end report
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tlast && rsp_tdata == 24'd0)
      else $error("malformed bare end report");

   // No result right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind json_string_escaper jse_checker u_jse_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

>>> bench/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for json_string_escaper: stream stimulus, a predictor of the
// escaped output and an in-order checker of every result transaction.
// Depends on jse_pkg and the json_string_escaper top level.
module testbench;
   import jse_pkg::*;

   localparam logic [1:0] REQ_UNUSED    = 2'd3;
   localparam int         SETTLE_CYCLES = 32;
   localparam int         TIMEOUT_NS    = 3_000_000;
   localparam int         PHASE_ITEMS   = 127;

   // One emitted byte or end report
   typedef struct packed {
      logic [7:0]  out_byte;
      logic        byte_valid;
      logic        last;
      logic [15:0] total_length;
   } json_out_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // [7:0] in_byte
   logic [1:0]  req_tuser = 2'd0;    // [1:0] req_type
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;           // [7:0] out_byte, [23:8] total_length
   logic [0:0]  rsp_tuser;           // [0] byte_valid
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic        csr_index = 1'b0;
   logic [15:0] csr_wdata = 16'h0000;

   // Predictor state and configuration
   logic [15:0] model_capacity = CAPACITY_RESET;
   logic        model_esc_slash = 1'b0;
   logic        model_open = 1'b0;
   logic        model_truncated = 1'b0;
   logic [15:0] model_used = 16'h0000;

   json_out_type pending_bytes[$];
   int           error_count = 0;
   int           items_sent = 0;
   int           send_idle_pct = 31;
   int           recv_idle_pct = 49;

   json_string_escaper dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Stall the result side at random
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      if (nib < 4'd10) return 8'h30 + {4'h0, nib};
      return 8'h61 + {4'h0, nib} - 8'd10;
   endfunction

   function automatic void push_out(input logic [7:0] b, input logic v, input logic l,
                                    input logic [15:0] len);
      json_out_type r;
      r.out_byte     = b;
      r.byte_valid   = v;
      r.last         = l;
      r.total_length = len;
      pending_bytes.push_back(r);
   endfunction

   // Work out the bytes that one accepted request puts out
   function automatic void escape_predict(input logic [1:0] kind, input logic [7:0] c);
      logic [7:0]  seq [6];
      int          len;
      logic [7:0]  esc;
      logic [16:0] free_bytes;
      len = 0;
      esc = 8'h00;
      case (kind)
         REQ_BEGIN: begin
            model_open      = 1'b0;
            model_truncated = 1'b0;
            model_used      = 16'h0000;
            if (model_capacity > 16'd2) begin
               model_open = 1'b1;
               model_used = 16'd1;
               push_out(CHAR_QUOTE, 1'b1, 1'b0, 16'h0000);
            end
         end
         REQ_END: begin
            if (model_open) push_out(CHAR_QUOTE, 1'b1, 1'b1, model_used + 16'd1);
            else            push_out(8'h00, 1'b0, 1'b1, 16'h0000);
            model_open      = 1'b0;
            model_truncated = 1'b0;
            model_used      = 16'h0000;
         end
         REQ_BYTE: begin
            if (model_open && !model_truncated) begin
               if (c >= CHAR_SPACE) begin
                  if (c == CHAR_QUOTE || c == CHAR_BSLASH ||
                      (c == CHAR_SLASH && model_esc_slash)) begin
                     seq[0] = CHAR_BSLASH;
                     seq[1] = c;
                     len = 2;
                  end else begin
                     seq[0] = c;
                     len = 1;
                  end
               end else begin
                  case (c)
                     CTRL_BS:  esc = CHAR_LC_B;
                     CTRL_FF:  esc = CHAR_LC_F;
                     CTRL_LF:  esc = CHAR_LC_N;
                     CTRL_CR:  esc = CHAR_LC_R;
                     CTRL_TAB: esc = CHAR_LC_T;
                     default:  esc = 8'h00;
                  endcase
                  if (esc != 8'h00) begin
                     seq[0] = CHAR_BSLASH;
                     seq[1] = esc;
                     len = 2;
                  end else begin
                     seq[0] = CHAR_BSLASH;
                     seq[1] = CHAR_U;
                     seq[2] = CHAR_ZERO;
                     seq[3] = CHAR_ZERO;
                     seq[4] = hex_char(c[7:4]);
                     seq[5] = hex_char(c[3:0]);
                     len = 6;
                  end
               end
               // No wrap: an exhausted budget leaves zero free bytes
               free_bytes = (model_capacity > model_used) ?
                            {1'b0, model_capacity} - {1'b0, model_used} : 17'd0;
               if (free_bytes < len + 2) begin
                  model_truncated = 1'b1;
               end else begin
                  for (int i = 0; i < len; i++) push_out(seq[i], 1'b1, 1'b0, 16'h0000);
                  model_used = model_used + len[15:0];
               end
            end
         end
         default: ;
      endcase
   endfunction

   // Compare each result transaction with the oldest expected byte
   always @(posedge clock) begin
      json_out_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_bytes.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("%0t: unexpected result byte=%h valid=%b last=%b len=%0d",
                        $realtime, rsp_tdata[7:0], rsp_tuser[0], rsp_tlast, rsp_tdata[23:8]);
         end else begin
            want = pending_bytes.pop_front();
            if (rsp_tdata[7:0] !== want.out_byte || rsp_tuser[0] !== want.byte_valid ||
                rsp_tlast !== want.last || rsp_tdata[23:8] !== want.total_length) begin
               error_count++;
               if (error_count <= 10)
                  $display("%0t: exp byte=%h v=%b l=%b len=%0d got byte=%h v=%b l=%b len=%0d",
                           $realtime, want.out_byte, want.byte_valid, want.last,
                           want.total_length, rsp_tdata[7:0], rsp_tuser[0], rsp_tlast,
                           rsp_tdata[23:8]);
            end
         end
      end
   end

   // Offer one request transaction and predict its output once accepted
   task automatic send_request(input logic [1:0] kind, input logic [7:0] data);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= data;
      do @(posedge clock); while (!req_tready);
      escape_predict(kind, data);
      items_sent++;
      @(negedge clock);
   endtask

   // Hold off the input until every expected byte is out and the block has settled
   task automatic wait_output_drained();
      req_tvalid <= 1'b0;
      while (pending_bytes.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(input logic index, input logic [15:0] value);
      wait_output_drained();
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      if (index == CSR_CAPACITY) model_capacity = value;
      else                       model_esc_slash = value[0];
   endtask

   task automatic test_reset();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
   endtask

   // Plain bytes, every short escape, unicode escapes, the high range and an unused kind
   task automatic test_escape_forms();
      send_request(REQ_BEGIN, 8'hff);
      send_request(REQ_BYTE, 8'h41);
      send_request(REQ_BYTE, CHAR_QUOTE);
      send_request(REQ_BYTE, CHAR_BSLASH);
      send_request(REQ_BYTE, CHAR_SLASH);
      send_request(REQ_BYTE, CTRL_BS);
      send_request(REQ_BYTE, CTRL_FF);
      send_request(REQ_BYTE, CTRL_LF);
      send_request(REQ_BYTE, CTRL_CR);
      send_request(REQ_BYTE, CTRL_TAB);
      send_request(REQ_BYTE, 8'h00);
      send_request(REQ_BYTE, 8'h1f);
      send_request(REQ_BYTE, 8'h7f);
      send_request(REQ_BYTE, 8'hff);
      send_request(REQ_UNUSED, 8'h5a);
      send_request(REQ_END, 8'h00);
   endtask

   // Slash escaping, stray requests while closed and restarting an open string
   task automatic test_slash_and_closed();
      write_register(CSR_ESC_SLASH, 16'h0001);
      send_request(REQ_BYTE, 8'h61);
      send_request(REQ_END, 8'h00);
      send_request(REQ_BEGIN, 8'h00);
      send_request(REQ_BYTE, CHAR_SLASH);
      send_request(REQ_BEGIN, 8'h00);
      send_request(REQ_BYTE, CHAR_SLASH);
      send_request(REQ_END, 8'h00);
      write_register(CSR_ESC_SLASH, 16'h0000);
   endtask

   // Budgets too small to open, the exact fit limits and truncation
   task automatic test_capacity_limits();
      write_register(CSR_CAPACITY, 16'd0);
      send_request(REQ_BEGIN, 8'h00);
      send_request(REQ_BYTE, 8'h41);
      send_request(REQ_END, 8'h00);
      write_register(CSR_CAPACITY, 16'd2);
      send_request(REQ_BEGIN, 8'h00);
      send_request(REQ_END, 8'h00);
      write_register(CSR_CAPACITY, 16'd4);
      send_request(REQ_BEGIN, 8'h00);
      send_request(REQ_BYTE, 8'h41);
      send_request(REQ_BYTE, 8'h42);
      send_request(REQ_END, 8'h00);
      write_register(CSR_CAPACITY, 16'd9);
      send_request(REQ_BEGIN, 8'h00);
      send_request(REQ_BYTE, 8'h01);
      send_request(REQ_BYTE, CHAR_QUOTE);
      send_request(REQ_END, 8'h00);
      write_register(CSR_CAPACITY, 16'hffff);
      send_request(REQ_BEGIN, 8'h00);
      send_request(REQ_BYTE, 8'h7e);
      // Lower the budget under an open string; the closing quote still goes out
      write_register(CSR_CAPACITY, 16'd0);
      send_request(REQ_BYTE, 8'h20);
      send_request(REQ_END, 8'h00);
      write_register(CSR_CAPACITY, CAPACITY_RESET);
   endtask

   function automatic logic [7:0] random_source_byte();
      int pick;
      logic [7:0] specials [8];
      specials = '{CHAR_QUOTE, CHAR_BSLASH, CHAR_SLASH, CTRL_BS, CTRL_FF, CTRL_LF,
                   CTRL_CR, CTRL_TAB};
      pick = $urandom_range(99);
      if (pick < 25) return 8'($urandom_range(8'h1f));
      if (pick < 40) return specials[$urandom_range(7)];
      if (pick < 75) return 8'($urandom_range(8'h7e, 8'h20));
      return 8'($urandom_range(8'hff, 8'h7f));
   endfunction

   task automatic retune_registers();
      int pick;
      logic [15:0] cap;
      pick = $urandom_range(99);
      if      (pick < 40) cap = 16'($urandom_range(30, 3));
      else if (pick < 80) cap = 16'($urandom_range(300, 31));
      else if (pick < 88) cap = 16'hffff;
      else if (pick < 95) cap = 16'($urandom_range(2));
      else                cap = 16'($urandom);
      write_register(CSR_CAPACITY, cap);
      if ($urandom_range(1)) write_register(CSR_ESC_SLASH, 16'($urandom));
   endtask

   // Mostly well-formed strings with random content, plus stray and broken sequences
   task automatic test_random_strings(input int item_goal);
      int stop_at;
      int count;
      int pick;
      stop_at = items_sent + item_goal;
      while (items_sent < stop_at) begin
         if ($urandom_range(99) < 30) retune_registers();
         pick = $urandom_range(99);
         if (pick < 4)       send_request(REQ_UNUSED, 8'($urandom));
         else if (pick < 8)  send_request(REQ_BYTE, random_source_byte());
         else if (pick < 11) send_request(REQ_END, 8'($urandom));
         send_request(REQ_BEGIN, 8'($urandom));
         count = $urandom_range(20);
         for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            if (pick < 3)      send_request(REQ_BEGIN, 8'($urandom));
            else if (pick < 6) send_request(REQ_UNUSED, 8'($urandom));
            else               send_request(REQ_BYTE, random_source_byte());
         end
         if ($urandom_range(99) < 92) send_request(REQ_END, 8'($urandom));
      end
   endtask

   initial begin
      test_reset();
      test_escape_forms();
      test_slash_and_closed();
      test_capacity_limits();
      test_random_strings(PHASE_ITEMS - 50);
      send_idle_pct = 49;
      recv_idle_pct = 31;
      test_random_strings(PHASE_ITEMS);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_strings(PHASE_ITEMS);
      wait_output_drained();
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
